@@ rtl/core/rpn_pkg.sv @@
`default_nettype none
// Shared types, codes and controller/datapath structs for the RPN evaluator.
package rpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;

  typedef logic [2:0]         action_t;
  typedef logic [2:0]         status_t;
  typedef logic signed [31:0] value_t;

  localparam action_t ACT_PUSH    = 3'd0;
  localparam action_t ACT_ADD     = 3'd1;
  localparam action_t ACT_SUB     = 3'd2;
  localparam action_t ACT_MUL     = 3'd3;
  localparam action_t ACT_DIV     = 3'd4;
  localparam action_t ACT_FINISH  = 3'd5;
  localparam action_t ACT_UNKNOWN = 3'd6;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_ZDIV    = 3'd3;
  localparam status_t ST_UNKNOWN = 3'd4;

  typedef struct packed {
    logic load;
    logic res_opnd;
    logic pop_r;
    logic pop_l;
    logic res_pop;
    logic note_zdiv;
    logic note_unknown;
    logic exec;
    logic res_mul;
    logic res_div;
    logic push;
    logic emit;
  } rpn_cmd_t;

  typedef struct packed {
    action_t act;
    logic    sp_zero;
    logic    rd_zero;
    logic    div_done;
  } rpn_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/rpn_tok_if.sv @@
`default_nettype none
// Token input channel: valid/ready handshake with action and operand.
interface rpn_tok_if;
  import rpn_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  value_t  operand_value;

  modport source (output valid, output action, output operand_value, input ready);
  modport sink (input valid, input action, input operand_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rpn_res_if.sv @@
`default_nettype none
// Result output channel: valid/ready handshake with value and status.
interface rpn_res_if;
  import rpn_pkg::*;

  logic    valid;
  logic    ready;
  value_t  top_value;
  status_t status;

  modport source (output valid, output top_value, output status, input ready);
  modport sink (input valid, input top_value, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rpn_stack_evaluator_core.sv @@
`default_nettype none
// RPN stack evaluator: token in on tok, one result beat out on res per token.
//
// Each tok beat carries one token (push, add, subtract, multiply, divide,
// finish, unknown) and an operand used by push. Every token produces exactly
// one res beat with the value pushed or popped and a status code. Values are
// signed Q16.16; add/subtract wrap, multiply/divide saturate.
// One token is worked at a time; tok.ready is high only when the controller
// is idle. Divide is paced by the bit-serial divider (33 quotient bits, one
// per cycle); the other tokens by the registered stack RAM read, with a wait
// state between two pops. res holds its beat in an output register; the
// next token is taken while it waits, and a stalled receiver only holds the
// block when a second result is ready to go out. Reset empties the stack
// (pointer to zero) and drops any pending result; the stack RAM itself is
// not cleared.
module rpn_stack_evaluator_core #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  rpn_tok_if.sink    tok,
  rpn_res_if.source  res
);
  import rpn_pkg::*;

  rpn_cmd_t cmd;
  rpn_sts_t sts;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok.valid),
    .tok_ready (tok.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (tok.action),
    .operand_value (tok.operand_value),
    .top_value     (res.top_value),
    .status        (res.status)
  );

endmodule
`default_nettype wire

@@ rtl/core/rpn_ram.sv @@
`default_nettype none
// Generic simple dual-port RAM, one write and one registered read port.
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/rpn_div.sv @@
`default_nettype none
// Bit-serial Q16.16 divider: restoring, one quotient bit per cycle, saturating.
module rpn_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rpn_pkg::value_t dividend,
  input  rpn_pkg::value_t divisor,
  output logic            done,
  output rpn_pkg::value_t quotient
);
  import rpn_pkg::*;

  localparam int unsigned STEPS = 33;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      rem;
  logic [32:0]      num;
  logic [32:0]      quo;
  logic [31:0]      dmag;
  logic             neg;
  logic             ovf;

  logic [31:0]      lmag;
  logic [31:0]      rmag;
  logic [32:0]      trial;
  logic             fits;

  assign lmag  = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign rmag  = divisor[31] ? (~divisor + 32'd1) : divisor;
  assign trial = {rem, num[32]};
  assign fits  = (trial >= {1'b0, dmag});

  always_comb begin
    if (ovf) begin
      quotient = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!neg) begin
      quotient = (quo[32] || quo[31]) ? 32'h7FFF_FFFF : quo[31:0];
    end else begin
      quotient = (quo[32] || (quo[31] && |quo[30:0])) ? 32'h8000_0000
                                                     : (~quo[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // high dividend bits seed the remainder; overflow if they already reach the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {17'd0, lmag[31:17]};
      num  <= {lmag[16:0], 16'd0};
      quo  <= '0;
      dmag <= rmag;
      neg  <= dividend[31] ^ divisor[31];
      ovf  <= ({17'd0, lmag[31:17]} >= rmag);
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, dmag}) : trial[31:0];
      num <= {num[31:0], 1'b0};
      quo <= {quo[31:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rpn_dp.sv @@
`default_nettype none
// Datapath: stack pointer, stack RAM, operand registers, ALU and result registers.
module rpn_dp #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rpn_pkg::rpn_cmd_t cmd,
  output rpn_pkg::rpn_sts_t sts,
  input  rpn_pkg::action_t  action,
  input  rpn_pkg::value_t   operand_value,
  output rpn_pkg::value_t   top_value,
  output rpn_pkg::status_t  status
);
  import rpn_pkg::*;

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);

  logic [SP_W-1:0]    sp;
  logic [SP_W-1:0]    sp_m1;
  action_t            act;
  value_t             opnd;
  value_t             r_val;
  value_t             l_val;
  value_t             res;
  status_t            st;
  logic signed [63:0] prod;

  logic [31:0]        rdata;
  logic               we;
  value_t             pop_val;
  value_t             mul_sat;
  value_t             div_q;
  logic               div_done;
  logic               sp_zero;
  logic               sp_full;
  logic               popping;
  status_t            err;

  assign sp_m1   = sp - SP_W'(1);
  assign sp_zero = (sp == '0);
  assign sp_full = (sp == SP_W'(STACK_DEPTH));
  assign we      = cmd.push && !sp_full;
  assign popping = cmd.pop_r || cmd.pop_l;
  assign pop_val = sp_zero ? '0 : rdata;

  assign sts.act      = act;
  assign sts.sp_zero  = sp_zero;
  assign sts.rd_zero  = (rdata == '0);
  assign sts.div_done = div_done;

  rpn_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (sp[AW-1:0]),
    .wdata (res),
    .raddr (sp_m1[AW-1:0]),
    .rdata (rdata)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && (act == ACT_DIV)),
    .dividend (l_val),
    .divisor  (r_val),
    .done     (div_done),
    .quotient (div_q)
  );

  // floor shift by 16, then clamp to Q16.16
  always_comb begin
    if (!prod[63] && |prod[62:47]) begin
      mul_sat = 32'h7FFF_FFFF;
    end else if (prod[63] && !(&prod[62:47])) begin
      mul_sat = 32'h8000_0000;
    end else begin
      mul_sat = prod[47:16];
    end
  end

  always_comb begin
    err = ST_OK;
    if (popping && sp_zero) begin
      err = ST_EMPTY;
    end else if (cmd.note_zdiv) begin
      err = ST_ZDIV;
    end else if (cmd.note_unknown) begin
      err = ST_UNKNOWN;
    end else if (cmd.push && sp_full) begin
      err = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (popping && !sp_zero) begin
      sp <= sp_m1;
    end else if (we) begin
      sp <= sp + SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action;
      opnd <= operand_value;
      res  <= '0;
      st   <= ST_OK;
    end else begin
      if (st == ST_OK) begin
        st <= err;
      end
      if (cmd.res_opnd) begin
        res <= opnd;
      end
      if (cmd.pop_r) begin
        r_val <= pop_val;
      end
      if (cmd.pop_l) begin
        l_val <= pop_val;
      end
      if (cmd.res_pop) begin
        res <= pop_val;
      end
      if (cmd.exec) begin
        prod <= l_val * r_val;
        case (act)
          ACT_ADD: res <= l_val + r_val;
          ACT_SUB: res <= l_val - r_val;
          default: ;
        endcase
      end
      if (cmd.res_mul) begin
        res <= mul_sat;
      end
      if (cmd.res_div) begin
        res <= div_q;
      end
      if (cmd.emit) begin
        top_value <= res;
        status    <= st;
      end
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    popping |=> (sp == $past(sp_m1)) || ($past(sp_zero) && sp_zero))
    else $error("pop did not move stack pointer by one");

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (st == ST_OK))
    else $error("status not cleared at token load");
`endif

endmodule
`default_nettype wire

@@ rtl/core/rpn_ctrl.sv @@
`default_nettype none
// Controller: sequences one token at a time through the datapath.
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  output logic              tok_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  rpn_pkg::rpn_sts_t sts,
  output rpn_pkg::rpn_cmd_t cmd
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_R,
    S_WAIT_L,
    S_POP_L,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_PUSH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;

  assign tok_ready = (state == S_IDLE) && !rst;
  assign res_valid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tok_valid && tok_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.act)
          ACT_PUSH: begin
            cmd.res_opnd = 1'b1;
            state_next   = S_PUSH;
          end
          ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_FINISH: begin
            state_next = S_POP_R;
          end
          ACT_UNKNOWN: begin
            cmd.note_unknown = 1'b1;
            state_next       = S_EMIT;
          end
          default: begin
            cmd.note_unknown = 1'b1;
            state_next       = S_EMIT;
          end
        endcase
      end
      S_POP_R: begin
        cmd.pop_r = 1'b1;
        case (sts.act)
          ACT_FINISH: begin
            cmd.res_pop = 1'b1;
            state_next  = S_EMIT;
          end
          ACT_DIV: begin
            if (sts.sp_zero) begin
              state_next = S_EMIT;
            end else if (sts.rd_zero) begin
              cmd.note_zdiv = 1'b1;
              state_next    = S_EMIT;
            end else begin
              state_next = S_WAIT_L;
            end
          end
          default: state_next = S_WAIT_L;
        endcase
      end
      S_WAIT_L: state_next = S_POP_L;
      S_POP_L: begin
        cmd.pop_l  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.act)
          ACT_MUL: state_next = S_MUL;
          ACT_DIV: state_next = S_DIV;
          default: state_next = S_PUSH;
        endcase
      end
      S_MUL: begin
        cmd.res_mul = 1'b1;
        state_next  = S_PUSH;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.res_div = 1'b1;
          state_next  = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || res_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready |=> !tok_ready)
    else $error("second token taken while one is in flight");

  a_no_stale_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && (sts.act == ACT_DIV) |=> !sts.div_done)
    else $error("divider done right after start");
`endif

endmodule
`default_nettype wire

@@ sim/tb_rpn_stack_evaluator_core.sv @@
// Self-checking testbench for the RPN stack evaluator core: directed tokens, then random traffic.
module tb_rpn_stack_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  localparam int unsigned DEPTH        = STACK_DEPTH_DEF;
  localparam action_t     ACT_RESERVED = 3'd7;
  localparam int          ITEM_TARGET  = 400;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          IDLE_LIMIT   = 4000;

  typedef struct packed {
    value_t  top;
    status_t st;
  } result_t;

  typedef struct packed {
    action_t act;
    value_t  opnd;
    logic    typed_in;
    value_t  top;
    status_t st;
  } token_row_t;

  token_row_t directed_rows [25] = '{
    '{ACT_FINISH,   32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{ACT_ADD,      32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{ACT_FINISH,   32'h0,        1'b1, 32'h0,        ST_OK},
    '{ACT_DIV,      32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{ACT_UNKNOWN,  32'h12345678, 1'b1, 32'h0,        ST_UNKNOWN},
    '{ACT_RESERVED, 32'hFFFFFFFF, 1'b1, 32'h0,        ST_UNKNOWN},
    '{ACT_PUSH,     32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, ST_OK},
    '{ACT_PUSH,     32'h80000000, 1'b1, 32'h80000000, ST_OK},
    '{ACT_MUL,      32'h0,        1'b1, 32'h80000000, ST_OK},
    '{ACT_PUSH,     32'h0,        1'b1, 32'h0,        ST_OK},
    '{ACT_DIV,      32'h0,        1'b1, 32'h0,        ST_ZDIV},
    '{ACT_PUSH,     32'h1,        1'b1, 32'h1,        ST_OK},
    '{ACT_DIV,      32'h0,        1'b1, 32'h80000000, ST_OK},
    '{ACT_FINISH,   32'h0,        1'b1, 32'h80000000, ST_OK},
    '{ACT_PUSH,     32'h00020000, 1'b0, 32'h0,        ST_OK},
    '{ACT_DIV,      32'h0,        1'b1, 32'h0,        ST_EMPTY},
    '{ACT_FINISH,   32'h0,        1'b1, 32'h0,        ST_OK},
    '{ACT_PUSH,     32'hFFFFFFFF, 1'b0, 32'h0,        ST_OK},
    '{ACT_PUSH,     32'h00008000, 1'b0, 32'h0,        ST_OK},
    '{ACT_MUL,      32'h0,        1'b0, 32'h0,        ST_OK},
    '{ACT_PUSH,     32'h00030000, 1'b0, 32'h0,        ST_OK},
    '{ACT_SUB,      32'h0,        1'b0, 32'h0,        ST_OK},
    '{ACT_PUSH,     32'hFFFD0000, 1'b0, 32'h0,        ST_OK},
    '{ACT_DIV,      32'h0,        1'b0, 32'h0,        ST_OK},
    '{ACT_FINISH,   32'h0,        1'b0, 32'h0,        ST_OK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpn_tok_if tok_bus ();
  rpn_res_if res_bus ();

  rpn_stack_evaluator_core dut (
    .clk (clk),
    .rst (rst),
    .tok (tok_bus),
    .res (res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  value_t      stack_mem [DEPTH];
  int unsigned stack_cnt = 0;
  result_t     awaited_results [$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          hold_request = 1'b0;

  function automatic void note_status(inout status_t st, input status_t code);
    if (st == ST_OK) st = code;
  endfunction

  function automatic void pop_entry(output value_t v, inout status_t st);
    if (stack_cnt > 0) begin
      stack_cnt--;
      v = stack_mem[stack_cnt];
    end else begin
      v = '0;
      note_status(st, ST_EMPTY);
    end
  endfunction

  function automatic void push_entry(input value_t v, inout status_t st);
    if (stack_cnt < DEPTH) begin
      stack_mem[stack_cnt] = v;
      stack_cnt++;
    end else begin
      note_status(st, ST_FULL);
    end
  endfunction

  function automatic value_t clamp_q16(input longint v);
    if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (v < -longint'(64'sh80000000)) return 32'sh80000000;
    return value_t'(v[31:0]);
  endfunction

  // Applies one token to the shadow stack and returns the beat it must produce.
  function automatic void eval_token(input action_t act, input value_t opnd, output result_t r);
    value_t  lhs, rhs;
    status_t st;
    st    = ST_OK;
    r.top = '0;
    case (act)
      ACT_PUSH: begin
        r.top = opnd;
        push_entry(opnd, st);
      end
      ACT_ADD, ACT_SUB, ACT_MUL: begin
        pop_entry(rhs, st);
        pop_entry(lhs, st);
        if (act == ACT_ADD) r.top = lhs + rhs;
        else if (act == ACT_SUB) r.top = lhs - rhs;
        else r.top = clamp_q16((longint'(lhs) * longint'(rhs)) >>> 16);
        push_entry(r.top, st);
      end
      ACT_DIV: begin
        pop_entry(rhs, st);
        if (st == ST_OK) begin
          if (rhs == 0) begin
            note_status(st, ST_ZDIV);
          end else begin
            pop_entry(lhs, st);
            r.top = clamp_q16((longint'(lhs) * 64'sd65536) / longint'(rhs));
            push_entry(r.top, st);
          end
        end
      end
      ACT_FINISH: pop_entry(r.top, st);
      default: note_status(st, ST_UNKNOWN);
    endcase
    r.st = st;
  endfunction

  function automatic value_t pick_operand();
    case ($urandom_range(0, 7))
      0, 1: return value_t'($urandom);
      2, 3: return value_t'((int'($urandom_range(0, 40)) - 20) * 65536);
      4, 5: return value_t'(int'($urandom_range(0, 262143)) - 131072);
      6: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh1;
          default: return -32'sh1;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  task automatic send_token(input action_t act, input value_t opnd, input bit typed_in = 1'b0,
                            input value_t fix_top = '0, input status_t fix_st = ST_OK);
    result_t want;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        tok_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tok_bus.valid         <= 1'b1;
    tok_bus.action        <= act;
    tok_bus.operand_value <= opnd;
    do @(posedge clk); while (!tok_bus.ready);
    eval_token(act, opnd, want);
    if (typed_in) begin
      want.top = fix_top;
      want.st  = fix_st;
    end
    awaited_results.push_back(want);
    if (act <= ACT_FINISH) items_sent++;
  endtask

  // Well-formed expression: random operands and operators, closed by finish.
  task automatic send_expression();
    int operands, pushed, depth;
    operands = $urandom_range(1, 7);
    pushed   = 0;
    depth    = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        send_token(ACT_PUSH, pick_operand());
        pushed++;
        depth++;
      end else begin
        send_token(action_t'($urandom_range(ACT_ADD, ACT_DIV)), value_t'($urandom));
        depth--;
      end
    end
    send_token(ACT_FINISH, value_t'($urandom));
  endtask

  initial begin : stimulus
    tok_bus.valid         = 1'b0;
    tok_bus.action        = ACT_PUSH;
    tok_bus.operand_value = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_token(directed_rows[i].act, directed_rows[i].opnd, directed_rows[i].typed_in,
                 directed_rows[i].top, directed_rows[i].st);

    // fill past the top while the result side is held off, then drain
    hold_request = 1'b1;
    repeat (DEPTH - stack_cnt + 3) send_token(ACT_PUSH, pick_operand());
    while (stack_cnt > 1) begin
      if ($urandom_range(0, 3) == 0) send_token(ACT_FINISH, value_t'($urandom));
      else send_token(action_t'($urandom_range(ACT_ADD, ACT_DIV)), value_t'($urandom));
    end
    repeat (2) send_token(ACT_FINISH, value_t'($urandom));

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        send_expression();
      end else begin
        repeat ($urandom_range(1, 5))
          send_token(action_t'($urandom_range(0, 7)), value_t'($urandom));
      end
    end
    tok_bus.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int       mode;
    int       span;
    bit [7:0] ready_pat;
    res_bus.ready = 1'b0;
    forever begin
      mode      = $urandom_range(0, 3);
      span      = $urandom_range(16, 96);
      ready_pat = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          res_bus.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: res_bus.ready <= 1'b1;
            1: res_bus.ready <= 1'($urandom_range(0, 1));
            2: res_bus.ready <= ($urandom_range(0, 3) == 0);
            default: begin
              res_bus.ready <= ready_pat[0];
              ready_pat = {ready_pat[0], ready_pat[7:1]};
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat: value %h, status %0d", $time,
                   res_bus.top_value, res_bus.status);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (res_bus.top_value !== want.top) begin
            $display("%0t: top_value mismatch: expected %h, actual %h", $time, want.top,
                     res_bus.top_value);
            errors++;
          end
          if (res_bus.status !== want.st) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.st,
                     res_bus.status);
            errors++;
          end
        end
      end
      if ((res_bus.valid && res_bus.ready) || (tok_bus.valid && tok_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

@@ rpn_stack_evaluator_core.f @@
rtl/core/rpn_pkg.sv
rtl/core/rpn_tok_if.sv
rtl/core/rpn_res_if.sv
rtl/core/rpn_ram.sv
rtl/core/rpn_div.sv
rtl/core/rpn_dp.sv
rtl/core/rpn_ctrl.sv
rtl/core/rpn_stack_evaluator_core.sv
sim/tb_rpn_stack_evaluator_core.sv
